// ===== hdl/led_latch_display_and_banked_ram_core_assert.svh =====
// assertion macros shared by the checker of the led latch display core
// each expands to one labeled concurrent assertion clocked on aclk and gated by reset
`ifndef LED_LATCH_DISPLAY_AND_BANKED_RAM_CORE_ASSERT_SVH
`define LED_LATCH_DISPLAY_AND_BANKED_RAM_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define LLDBR_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define LLDBR_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lldbr_pkg.sv =====
// types and constants of the led latch display and banked ram core
// no dependencies; used by lldbr_front, lldbr_disp and the top level of the block
`timescale 1ns / 1ps

package lldbr_pkg;

    typedef enum logic [2:0] {
        REQ_PORT1_WR    = 3'd0,
        REQ_PORT2_WR    = 3'd1,
        REQ_RAM_RD      = 3'd2,
        REQ_RAM_WR      = 3'd3,
        REQ_TICK        = 3'd4,
        REQ_COL_SAMPLE  = 3'd5,
        REQ_FRAME_START = 3'd6
    } req_t;

    localparam int          LATCH_COUNT     = 5;
    localparam int          LED_BITS        = 8 * LATCH_COUNT;
    localparam int          COL_W           = 10;
    localparam logic [7:0]  BLANK_DELAY_RST = 8'd39;
    localparam logic [2:0]  SEL_BLANK       = 3'd0;
    localparam logic [2:0]  SEL_SOUND       = 3'd6;
    localparam logic [2:0]  SEL_LAST_LATCH  = 3'd5;
    localparam logic [7:0]  INVERT_MASK     = 8'hff;
    localparam int          STROBE_BIT      = 4;
    localparam int          EA_BIT          = 2;

    // item held between the bus front end and the display stage
    typedef struct packed {
        logic       valid;
        req_t       req;
        logic [7:0] data;
    } stage_t;

    typedef struct packed {
        logic [3:0]          sound_cmd;
        logic                sound_reset;
        logic                ea_line;
        logic [COL_W-1:0]    column_pos;
        logic [LED_BITS-1:0] led_column;
        logic [7:0]          read_data;
        logic                column_valid;
    } result_t;

endpackage

// ===== hdl/lldbr_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module lldbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/lldbr_front.sv =====
// bus front end: input acceptance, bank register, ram addressing and clearing pass
// depends on lldbr_pkg; drives the ports of lldbr_ram
`timescale 1ns / 1ps

module lldbr_front #(
    parameter int RAM_DEPTH = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  lldbr_pkg::req_t              req,
    input  logic [7:0]                   offset,
    input  logic [7:0]                   wdata,
    input  logic                         stage_adv,
    output lldbr_pkg::stage_t            stage,
    output logic                         ram_we,
    output logic [$clog2(RAM_DEPTH)-1:0] ram_waddr,
    output logic [7:0]                   ram_wdata,
    output logic                         ram_re,
    output logic [$clog2(RAM_DEPTH)-1:0] ram_raddr
);

    localparam int             AW         = $clog2(RAM_DEPTH);
    localparam int             WRAP_STEPS = 1023 / RAM_DEPTH;
    localparam logic [10:0]    DEPTH_W    = 11'(RAM_DEPTH);
    localparam logic [AW-1:0]  LAST_ADDR  = AW'(RAM_DEPTH - 1);

    logic              clr_busy_reg, clr_busy_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic [1:0]        bank_reg, bank_next;
    lldbr_pkg::stage_t stage_reg, stage_next;
    logic              accept;
    logic [10:0]       addr_wrap;
    logic [AW-1:0]     addr;

    assign s_tready = !clr_busy_reg && (!stage_reg.valid || stage_adv);
    assign accept   = s_tvalid && s_tready;

    // bank*256 + offset, folded into the ram depth
    always_comb begin
        addr_wrap = {1'b0, bank_reg, offset};
        for (int i = 0; i < WRAP_STEPS; i++) begin
            if (addr_wrap >= DEPTH_W) begin
                addr_wrap = addr_wrap - DEPTH_W;
            end
        end
        addr = addr_wrap[AW-1:0];
    end

    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        bank_next     = bank_reg;
        stage_next    = stage_reg;
        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == LAST_ADDR) begin
                clr_busy_next = 1'b0;
            end
        end
        if (accept && req == lldbr_pkg::REQ_PORT1_WR) begin
            bank_next = wdata[1:0];
        end
        if (!stage_reg.valid || stage_adv) begin
            stage_next.valid = accept;
            stage_next.req   = req;
            stage_next.data  = wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg    <= 1'b1;
            clr_addr_reg    <= '0;
            bank_reg        <= '0;
            stage_reg.valid <= 1'b0;
        end else begin
            clr_busy_reg    <= clr_busy_next;
            clr_addr_reg    <= clr_addr_next;
            bank_reg        <= bank_next;
            stage_reg.valid <= stage_next.valid;
        end
        stage_reg.req  <= stage_next.req;
        stage_reg.data <= stage_next.data;
    end

    assign ram_we    = clr_busy_reg || (accept && req == lldbr_pkg::REQ_RAM_WR);
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : addr;
    assign ram_wdata = clr_busy_reg ? 8'd0 : wdata;
    assign ram_re    = accept && req == lldbr_pkg::REQ_RAM_RD;
    assign ram_raddr = addr;
    assign stage     = stage_reg;

endmodule

// ===== hdl/lldbr_disp.sv =====
// display stage: latches, led outputs, blanking timer, column counter and result register
// depends on lldbr_pkg; takes the item from lldbr_front and the ram read word
`timescale 1ns / 1ps

module lldbr_disp #(
    parameter int COLUMN_COUNT = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lldbr_pkg::stage_t     stage,
    input  logic [7:0]            ram_rdata,
    output logic                  stage_adv,
    input  logic                  cfg_valid,
    input  logic [7:0]            cfg_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lldbr_pkg::result_t    result
);

    localparam logic [lldbr_pkg::COL_W-1:0] COL_LAST = lldbr_pkg::COL_W'(COLUMN_COUNT - 1);

    logic                          ea_reg, ea_next;
    logic [2:0]                    sel_reg, sel_next;
    logic                          strobe_reg, strobe_next;
    logic                          en_reg, en_next;
    logic [7:0]                    latch_reg [lldbr_pkg::LATCH_COUNT];
    logic [7:0]                    latch_next [lldbr_pkg::LATCH_COUNT];
    logic [7:0]                    out_reg [lldbr_pkg::LATCH_COUNT];
    logic [7:0]                    out_next [lldbr_pkg::LATCH_COUNT];
    logic [7:0]                    cd_reg, cd_next;
    logic [lldbr_pkg::COL_W-1:0]   col_reg, col_next;
    logic                          snd_reg, snd_next;
    logic [3:0]                    nib_reg, nib_next;
    logic [7:0]                    delay_reg;
    logic                          m_valid_reg, m_valid_next;
    lldbr_pkg::result_t            res_reg, res_next;
    logic                          fire;
    logic [2:0]                    latch_idx;
    logic [lldbr_pkg::LED_BITS-1:0] led_bits;

    assign stage_adv = !m_valid_reg || m_ready;
    assign fire      = stage.valid && stage_adv;
    // select 1..5 maps to latch 4..0
    assign latch_idx = lldbr_pkg::SEL_LAST_LATCH - sel_reg;

    always_comb begin
        for (int b = 0; b < lldbr_pkg::LATCH_COUNT; b++) begin
            for (int y = 0; y < 8; y++) begin
                led_bits[8*b + y] = out_reg[b][7-y] & en_reg;
            end
        end
    end

    always_comb begin
        ea_next      = ea_reg;
        sel_next     = sel_reg;
        strobe_next  = strobe_reg;
        en_next      = en_reg;
        latch_next   = latch_reg;
        out_next     = out_reg;
        cd_next      = cd_reg;
        col_next     = col_reg;
        snd_next     = snd_reg;
        nib_next     = nib_reg;
        m_valid_next = m_valid_reg && !m_ready;
        res_next     = res_reg;
        res_next.read_data    = '0;
        res_next.led_column   = '0;
        res_next.column_pos   = '0;
        res_next.column_valid = 1'b0;
        if (fire) begin
            case (stage.req)
                lldbr_pkg::REQ_PORT1_WR: begin
                    ea_next = stage.data[lldbr_pkg::EA_BIT];
                end
                lldbr_pkg::REQ_PORT2_WR: begin
                    sel_next = stage.data[7:5];
                    if (sel_next == lldbr_pkg::SEL_BLANK && cd_reg == 8'd0) begin
                        cd_next = (delay_reg != 8'd0) ? delay_reg : 8'd1;
                    end
                    if (!strobe_reg && stage.data[lldbr_pkg::STROBE_BIT]) begin
                        out_next = latch_reg;
                        cd_next  = 8'd0;
                        en_next  = 1'b1;
                    end
                    strobe_next = stage.data[lldbr_pkg::STROBE_BIT];
                    nib_next    = stage.data[7:4];
                end
                lldbr_pkg::REQ_RAM_RD: begin
                    res_next.read_data = ram_rdata;
                    if (sel_reg != lldbr_pkg::SEL_BLANK && sel_reg <= lldbr_pkg::SEL_LAST_LATCH) begin
                        latch_next[latch_idx] = ram_rdata ^ lldbr_pkg::INVERT_MASK;
                    end else if (sel_reg == lldbr_pkg::SEL_SOUND) begin
                        snd_next = !ram_rdata[0];
                    end
                end
                lldbr_pkg::REQ_TICK: begin
                    if (cd_reg != 8'd0) begin
                        cd_next = cd_reg - 8'd1;
                        if (cd_reg == 8'd1) begin
                            en_next = 1'b0;
                        end
                    end
                end
                lldbr_pkg::REQ_COL_SAMPLE: begin
                    res_next.led_column   = led_bits;
                    res_next.column_pos   = col_reg;
                    res_next.column_valid = 1'b1;
                    if (col_reg < COL_LAST) begin
                        col_next = col_reg + lldbr_pkg::COL_W'(1);
                    end
                end
                lldbr_pkg::REQ_FRAME_START: begin
                    col_next = '0;
                end
                default: begin
                end
            endcase
            res_next.ea_line     = ea_next;
            res_next.sound_reset = snd_next;
            res_next.sound_cmd   = nib_next;
            m_valid_next         = 1'b1;
        end else begin
            res_next = res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ea_reg      <= 1'b0;
            sel_reg     <= '0;
            strobe_reg  <= 1'b0;
            en_reg      <= 1'b0;
            cd_reg      <= '0;
            col_reg     <= '0;
            snd_reg     <= 1'b1;
            nib_reg     <= '0;
            delay_reg   <= lldbr_pkg::BLANK_DELAY_RST;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < lldbr_pkg::LATCH_COUNT; i++) begin
                latch_reg[i] <= '0;
                out_reg[i]   <= '0;
            end
        end else begin
            ea_reg      <= ea_next;
            sel_reg     <= sel_next;
            strobe_reg  <= strobe_next;
            en_reg      <= en_next;
            cd_reg      <= cd_next;
            col_reg     <= col_next;
            snd_reg     <= snd_next;
            nib_reg     <= nib_next;
            m_valid_reg <= m_valid_next;
            latch_reg   <= latch_next;
            out_reg     <= out_next;
            if (cfg_valid) begin
                delay_reg <= cfg_data;
            end
        end
        res_reg <= res_next;
    end

    assign m_valid = m_valid_reg;
    assign result  = res_reg;

endmodule

// ===== hdl/led_latch_display_and_banked_ram_core.sv =====
// Top level of the led latch display and banked ram core. After reset the ram is
// cleared one byte per cycle, and s_tready stays low until that pass is done; the
// blank delay register can be written at any time (cfg_ready is always high). After
// that one word is accepted every cycle as long as the result side keeps up. Each
// word gives exactly one result word: it is registered in the front end stage along
// with the registered ram read, then the display stage updates latches, outputs,
// timer and column counter and loads the output register.
// Depends on lldbr_pkg, lldbr_ram, lldbr_front and lldbr_disp.
`timescale 1ns / 1ps

module led_latch_display_and_banked_ram_core #(
    parameter int RAM_DEPTH    = 1024,
    parameter int COLUMN_COUNT = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // port_offset[7:0], write_data[15:8]
    input  logic [2:0]  s_tuser,  // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // read_data[7:0], led_column[47:8], column_pos[57:48],
                                  // ea_line[58], sound_reset[59], sound_cmd[63:60]
    output logic [0:0]  m_tuser,  // column_valid[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    localparam int AW = $clog2(RAM_DEPTH);

    lldbr_pkg::stage_t  stage;
    lldbr_pkg::result_t result;
    logic               stage_adv;
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [7:0]         ram_wdata, ram_rdata;

    lldbr_front #(
        .RAM_DEPTH (RAM_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .req       (lldbr_pkg::req_t'(s_tuser)),
        .offset    (s_tdata[7:0]),
        .wdata     (s_tdata[15:8]),
        .stage_adv (stage_adv),
        .stage     (stage),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr)
    );

    lldbr_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    lldbr_disp #(
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_disp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .stage     (stage),
        .ram_rdata (ram_rdata),
        .stage_adv (stage_adv),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .result    (result)
    );

    assign cfg_ready = 1'b1;
    assign m_tdata   = {result.sound_cmd, result.sound_reset, result.ea_line,
                        result.column_pos, result.led_column, result.read_data};
    assign m_tuser   = result.column_valid;

endmodule

// ===== hdl/lldbr_checker.sv =====
// port level checks of the led latch display core, bound to its top level
// depends on led_latch_display_and_banked_ram_core_assert.svh
`timescale 1ns / 1ps
`include "led_latch_display_and_banked_ram_core_assert.svh"

module lldbr_checker #(
    parameter int COLUMN_COUNT = 1024
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [0:0]  m_tuser
);

    localparam logic [9:0] COL_LAST = 10'(COLUMN_COUNT - 1);

    `LLDBR_CHECK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled output word changed")
    `LLDBR_CHECK_NOW(a_no_col_fields, m_tvalid && !m_tuser[0], m_tdata[57:8] == 50'd0, "column fields set on a non-column word")
    `LLDBR_CHECK_NOW(a_col_range, m_tvalid, m_tdata[57:48] <= COL_LAST, "column position past the last column")
    `LLDBR_CHECK_NOW(a_clear_after_reset, !$past(aresetn), !s_tready, "input taken before the ram clearing pass")

endmodule

bind led_latch_display_and_banked_ram_core lldbr_checker #(
    .COLUMN_COUNT (COLUMN_COUNT)
) u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
